// File: rtl/ghi_pkg.sv
// ----------------------------------------------------------------------------
// ghi_pkg
// Shared constants for the gyro heading integrator: field widths, register
// indexes, reset values and the fixed scale factors of the trim and drive paths.
// ----------------------------------------------------------------------------
`default_nettype none

package ghi_pkg;

  // defaults for the top-level parameters
  localparam int CAL_SAMPLES_DEF = 100;
  localparam int FRAC_BITS_DEF   = 16;

  // field widths
  localparam int RATE_W   = 16;
  localparam int TRIM_W   = 10;
  localparam int OFFSET_W = 11;
  localparam int DRIVE_W  = 10;
  localparam int HEAD_W   = 64;
  localparam int BIAS_W   = 40;
  localparam int WCNT_W   = 10;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_CENTER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_OFFSET = 1'b1;

  localparam logic [TRIM_W-1:0]          TRIM_CENTER_RST = 10'd512;
  localparam logic signed [OFFSET_W-1:0] TRIM_OFFSET_RST = 11'sd20;

  // trim scaling: (adc - center) / TrimDiv
  localparam int TRIM_DIV   = 50;
  // adc - center is shifted up by TrimPadSteps * TrimDiv to stay non-negative
  localparam int TRIM_PAD_STEPS = 21;
  localparam int TRIM_CODE_W    = 12;
  // reciprocal precision beyond FRAC_BITS: 12 operand bits + 6 divisor bits
  localparam int TRIM_EXTRA = 18;

  // drive scaling: heading / 480 + 512, clamped to 0..1023
  localparam int OUT_DIV = 480;
  localparam int OUT_MID = 512;
  localparam int OUT_MAX = 1023;
  // 480 = 15 * 32: shift by five, then reciprocal of 15
  localparam int OUT_SHIFT  = 5;
  localparam int OUT_ODD    = 15;
  localparam int OUT_RK     = 18;
  localparam int OUT_RECIP  = ((1 << OUT_RK) + OUT_ODD - 1) / OUT_ODD;
  localparam int OUT_SPAN_W = 19;

endpackage

`default_nettype wire

// File: rtl/gyro_heading_integrator.sv
// ----------------------------------------------------------------------------
// gyro_heading_integrator
// Trapezoidal yaw-rate integrator with trim, drift-bias calibration and a
// clamped 10-bit drive output.
// ----------------------------------------------------------------------------
// One beat is taken per clock while the result side does not stall. A beat
// lands in an input register (trim reciprocal product), is folded into the
// 64-bit saturating heading from there, and the drive level is then registered
// from the heading. The heading register is the one loop. The exception is the
// end of a calibration window: the new drift bias is the floored quotient of
// the negated heading change by CAL_SAMPLES, found one 8-bit digit per cycle
// with a reciprocal multiply, and input beats stall while it runs. Start beats
// and calibration samples give no result.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_heading_integrator #(
  parameter int CAL_SAMPLES = ghi_pkg::CAL_SAMPLES_DEF,
  parameter int FRAC_BITS   = ghi_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [ghi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ghi_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   func,
  input  logic signed [ghi_pkg::RATE_W-1:0]      rate_z,
  input  logic [ghi_pkg::TRIM_W-1:0]             trim_adc,
  input  logic                                   clear_heading,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ghi_pkg::DRIVE_W-1:0]            drive_level,
  output logic                                   clamped
);

  localparam int HW = ghi_pkg::HEAD_W;
  localparam int BW = ghi_pkg::BIAS_W;
  localparam int CW = ghi_pkg::TRIM_CODE_W;

  // trim reciprocal
  localparam int TRIM_K  = FRAC_BITS + ghi_pkg::TRIM_EXTRA;
  localparam int TRIM_MW = FRAC_BITS + 13;
  localparam longint unsigned TRIM_M =
      ((64'd1 << TRIM_K) + ghi_pkg::TRIM_DIV - 1) / ghi_pkg::TRIM_DIV;
  localparam int PRODW   = CW + TRIM_MW;
  localparam int TRIM_QW = PRODW - ghi_pkg::TRIM_EXTRA;
  localparam int TRIM_PAD_CODE = ghi_pkg::TRIM_PAD_STEPS * ghi_pkg::TRIM_DIV;

  // calibration divider: |heading change| < 2^(FRAC_BITS+26), taken 8 bits
  // at a time; each step divides remainder:digit by a reciprocal multiply
  localparam int DMW    = FRAC_BITS + 26;
  localparam int REM_W  = $clog2(CAL_SAMPLES) + 1;
  localparam int DIG_W  = 8;
  localparam int NDIG   = (DMW + DIG_W - 1) / DIG_W;
  localparam int NUM_W  = NDIG * DIG_W;
  localparam int XW     = REM_W + DIG_W;
  localparam int DIV_RK = XW + REM_W;
  localparam int PW     = XW + DIV_RK + 1;
  localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_RK) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int DIV_CW = $clog2(NDIG);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(NDIG - 1);
  localparam logic [ghi_pkg::WCNT_W-1:0] CNT_LAST = ghi_pkg::WCNT_W'(CAL_SAMPLES - 1);

  localparam logic signed [HW-1:0] HEAD_MAX = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] HEAD_MIN = {1'b1, {(HW-1){1'b0}}};
  localparam logic signed [HW-1:0] BIAS_MAX = HW'({1'b0, {(BW-1){1'b1}}});
  localparam logic signed [HW-1:0] BIAS_MIN = -BIAS_MAX - 64'sd1;

  // drive conversion limits
  localparam longint OUT_LO_INT = -longint'(ghi_pkg::OUT_MID * ghi_pkg::OUT_DIV);
  localparam longint OUT_HI_INT =
      longint'((ghi_pkg::OUT_MAX + 1 - ghi_pkg::OUT_MID) * ghi_pkg::OUT_DIV) - 1;
  localparam logic signed [HW-1:0] CLAMP_HI =
      64'((ghi_pkg::OUT_MAX - ghi_pkg::OUT_MID) * ghi_pkg::OUT_DIV) <<< FRAC_BITS;
  localparam logic signed [HW-1:0] CLAMP_LO = 64'(OUT_LO_INT) <<< FRAC_BITS;
  localparam int SW = ghi_pkg::OUT_SPAN_W;
  localparam int WW = SW - ghi_pkg::OUT_SHIFT;
  localparam int LPW = WW + 15;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // configuration
  logic [ghi_pkg::TRIM_W-1:0]            trim_center;
  logic signed [ghi_pkg::OFFSET_W-1:0]   trim_offset;

  // input stage
  logic                                  a_valid;
  logic                                  a_func;
  logic signed [ghi_pkg::RATE_W-1:0]     a_rate;
  logic                                  a_clear;
  logic [PRODW-1:0]                      a_trim_prod;

  // integrator state
  logic                                  b_valid;
  logic signed [ghi_pkg::RATE_W-1:0]     previous_rate;
  logic signed [HW-1:0]                  heading_accum;
  logic signed [BW-1:0]                  drift_bias;
  logic                                  calibrating;
  logic [ghi_pkg::WCNT_W-1:0]            window_count;
  logic signed [HW-1:0]                  window_start_heading;

  // divider
  div_state_t                            div_state;
  logic [NUM_W-1:0]                      div_num;
  logic [REM_W-1:0]                      div_rem;
  logic                                  div_neg;
  logic [DIV_CW-1:0]                     div_cnt;

  // handshake
  logic b_mv, a_adv;

  assign b_mv     = b_valid && (!out_valid || out_ready);
  assign a_adv    = a_valid && (div_state == DIV_IDLE) && (!b_valid || b_mv);
  assign in_ready = !a_valid || a_adv;

  // trim product at the input
  logic [CW-1:0] trim_code;
  assign trim_code = CW'(trim_adc) - CW'(trim_center) + CW'(TRIM_PAD_CODE);

  // integrator datapath
  logic signed [ghi_pkg::RATE_W:0] rate_sum;
  logic [TRIM_QW-1:0]              trim_q;
  logic signed [HW-1:0]            avg, trim_term, offset_term, bias_term, inc;
  logic signed [HW-1:0]            base, sum, heading_upd;
  logic                            ovf, window_end;

  always_comb begin
    rate_sum    = {a_rate[ghi_pkg::RATE_W-1], a_rate}
                + {previous_rate[ghi_pkg::RATE_W-1], previous_rate};
    avg         = HW'(rate_sum) <<< (FRAC_BITS - 1);
    trim_q      = a_trim_prod[PRODW-1:ghi_pkg::TRIM_EXTRA];
    offset_term = HW'(trim_offset) <<< FRAC_BITS;
    trim_term   = $signed(HW'(trim_q)) - (64'(ghi_pkg::TRIM_PAD_STEPS) <<< FRAC_BITS)
                + offset_term;
    bias_term   = calibrating ? '0 : HW'(drift_bias);
    inc         = avg + trim_term + bias_term;
    base        = (!calibrating && a_clear) ? '0 : heading_accum;
    sum         = base + inc;
    ovf         = (base[HW-1] == inc[HW-1]) && (sum[HW-1] != base[HW-1]);
    heading_upd = ovf ? (inc[HW-1] ? HEAD_MIN : HEAD_MAX) : sum;
    window_end  = calibrating && (window_count == CNT_LAST);
  end

  // divider datapath
  logic signed [HW-1:0] diff64;
  logic [DMW:0]         diff, diff_mag;
  logic [XW-1:0]        dig_x, dig_rem;
  logic [PW-1:0]        dig_prod;
  logic [DIG_W-1:0]     dig_q;
  logic signed [HW-1:0] q_mag, q_full, q_sat;

  always_comb begin
    diff64   = window_start_heading - heading_accum;
    diff     = diff64[DMW:0];
    diff_mag = diff[DMW] ? (~diff + 1'b1) : diff;
    // remainder < CAL_SAMPLES, so each digit quotient fits 8 bits
    dig_x    = {div_rem, div_num[NUM_W-1 -: DIG_W]};
    dig_prod = PW'(dig_x) * PW'(DIV_RECIP);
    dig_q    = dig_prod[DIV_RK +: DIG_W];
    dig_rem  = dig_x - XW'(dig_q) * XW'(CAL_SAMPLES);
    q_mag    = $signed(HW'(div_num));
    q_full   = div_neg ? (-q_mag - HW'(|div_rem)) : q_mag;
    if (q_full > BIAS_MAX) begin
      q_sat = BIAS_MAX;
    end else if (q_full < BIAS_MIN) begin
      q_sat = BIAS_MIN;
    end else begin
      q_sat = q_full;
    end
  end

  // drive conversion from the heading register
  logic signed [HW-1:0] head_int;
  logic [SW-1:0]        span;
  logic [WW-1:0]        span_hi;
  logic [LPW-1:0]       lvl_prod;
  logic [ghi_pkg::DRIVE_W-1:0] level;
  logic                 clamp_flag;

  always_comb begin
    head_int = heading_accum >>> FRAC_BITS;
    span     = head_int[SW-1:0] + SW'(ghi_pkg::OUT_MID * ghi_pkg::OUT_DIV);
    span_hi  = span[SW-1:ghi_pkg::OUT_SHIFT];
    lvl_prod = LPW'(span_hi) * LPW'(ghi_pkg::OUT_RECIP);
    if (head_int < 64'(OUT_LO_INT)) begin
      level = '0;
    end else if (head_int > 64'(OUT_HI_INT)) begin
      level = ghi_pkg::DRIVE_W'(ghi_pkg::OUT_MAX);
    end else begin
      level = lvl_prod[ghi_pkg::OUT_RK +: ghi_pkg::DRIVE_W];
    end
    clamp_flag = (heading_accum > CLAMP_HI) || (heading_accum < CLAMP_LO);
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_center          <= ghi_pkg::TRIM_CENTER_RST;
      trim_offset          <= ghi_pkg::TRIM_OFFSET_RST;
      a_valid              <= 1'b0;
      b_valid              <= 1'b0;
      out_valid            <= 1'b0;
      previous_rate        <= '0;
      heading_accum        <= '0;
      drift_bias           <= '0;
      calibrating          <= 1'b0;
      window_count         <= '0;
      window_start_heading <= '0;
      div_state            <= DIV_IDLE;
      div_cnt              <= '0;
      div_rem              <= '0;
      div_neg              <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          ghi_pkg::CFG_TRIM_CENTER: trim_center <= cfg_wdata[ghi_pkg::TRIM_W-1:0];
          ghi_pkg::CFG_TRIM_OFFSET: trim_offset <= $signed(cfg_wdata);
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end

      if (b_mv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (a_adv) begin
        b_valid <= !a_func && !calibrating;
        if (a_func) begin
          // start beat; ignored while a window is open
          if (!calibrating) begin
            calibrating          <= 1'b1;
            window_count         <= '0;
            window_start_heading <= heading_accum;
          end
        end else begin
          previous_rate <= a_rate;
          heading_accum <= heading_upd;
          if (calibrating) begin
            if (window_end) begin
              calibrating  <= 1'b0;
              window_count <= '0;
              div_state    <= DIV_LOAD;
            end else begin
              window_count <= window_count + 1'b1;
            end
          end
        end
      end else if (b_mv) begin
        b_valid <= 1'b0;
      end

      case (div_state)
        DIV_LOAD: begin
          div_neg       <= diff[DMW];
          div_rem       <= '0;
          div_cnt       <= '0;
          heading_accum <= '0;
          div_state     <= DIV_RUN;
        end
        DIV_RUN: begin
          div_rem   <= dig_rem[REM_W-1:0];
          div_cnt   <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            div_state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          drift_bias <= q_sat[BW-1:0];
          div_state  <= DIV_IDLE;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_func      <= func;
      a_rate      <= rate_z;
      a_clear     <= clear_heading;
      a_trim_prod <= PRODW'(trim_code) * PRODW'(TRIM_M);
    end
    if (b_mv) begin
      drive_level <= level;
      clamped     <= clamp_flag;
    end
    if (div_state == DIV_LOAD) begin
      div_num <= NUM_W'(diff_mag[DMW-1:0]);
    end else if (div_state == DIV_RUN) begin
      div_num <= {div_num[NUM_W-DIG_W-1:0], dig_q};
    end
  end

endmodule

`default_nettype wire

// File: rtl/ghi_checker.sv
// ----------------------------------------------------------------------------
// ghi_checker
// Port-level checks for the gyro heading integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ghi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ghi_pkg::DRIVE_W-1:0]   drive_level,
  input logic                          clamped
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_level) && $stable(clamped))
    else $error("result beat changed while stalled");

  // a clamped level sits on a rail
  a_clamp_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |->
      (drive_level == '0) || (drive_level == ghi_pkg::DRIVE_W'(ghi_pkg::OUT_MAX)))
    else $error("clamped flag set off the rails");

  // no result comes out right after reset, before any input beat could reach the output
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid)
    else $error("result beat too soon after reset");

  // out_valid does not rise straight out of reset
  a_need_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst))
    else $error("result beat without input");

endmodule

bind gyro_heading_integrator ghi_checker u_ghi_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .drive_level (drive_level),
  .clamped     (clamped)
);

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gyro_heading_integrator. A scoreboard class tracks
// heading, drift bias and calibration windows for every accepted beat and
// checks each drive level and clamp flag in order. Stimulus is a directed
// opening followed by random bursts and calibration windows over several trim
// settings, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ghi_pkg::*;

  localparam int     CAL_LEN           = CAL_SAMPLES_DEF;
  localparam int     FRAC              = FRAC_BITS_DEF;
  localparam longint ONE               = longint'(1) << FRAC;
  localparam longint HEAD_HI           = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint HEAD_LO           = -HEAD_HI - 1;
  localparam longint BIAS_HI           = (longint'(1) << (BIAS_W - 1)) - 1;
  localparam longint BIAS_LO           = -BIAS_HI - 1;
  localparam logic   FUNC_SAMPLE       = 1'b0;
  localparam logic   FUNC_CAL_START    = 1'b1;
  localparam int     SAMPLES_PER_PHASE = 500;
  // covers the bias divider at window end plus pipeline depth
  localparam int     SETTLE_CYCLES     = FRAC + 28 + 8;
  localparam int     IDLE_LIMIT        = 1000;

  typedef struct packed {
    logic [DRIVE_W-1:0] level;
    logic               clamp;
  } drive_t;

  class heading_scoreboard;
    longint center;
    longint offset;
    longint prev_rate;
    longint heading;
    longint bias;
    longint win_start;
    bit     calibrating;
    int     win_count;
    drive_t drive_expected[$];
    int     mismatches;

    function new();
      center      = TRIM_CENTER_RST;
      offset      = TRIM_OFFSET_RST;
      prev_rate   = 0;
      heading     = 0;
      bias        = 0;
      win_start   = 0;
      calibrating = 0;
      win_count   = 0;
      mismatches  = 0;
    endfunction

    function longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a >= 0 && b >= 0 && s < 0) return HEAD_HI;
      if (a < 0 && b < 0 && s >= 0) return HEAD_LO;
      return s;
    endfunction

    function longint sat_sub(longint a, longint b);
      longint s;
      s = a - b;
      if (a >= 0 && b < 0 && s < 0) return HEAD_HI;
      if (a < 0 && b >= 0 && s >= 0) return HEAD_LO;
      return s;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TRIM_CENTER) center = longint'(data[TRIM_W-1:0]);
      else if (idx == CFG_TRIM_OFFSET) offset = $signed(data);
    endfunction

    function int pending();
      return drive_expected.size();
    endfunction

    // one accepted input beat: update heading state, queue the drive it yields
    function void advance_heading(logic fn, logic signed [RATE_W-1:0] rate,
                                  logic [TRIM_W-1:0] adc, logic clr);
      longint avg;
      longint trim;
      longint incr;
      longint q;
      drive_t want;
      if (fn == FUNC_CAL_START) begin
        if (!calibrating) begin
          calibrating = 1;
          win_count   = 0;
          win_start   = heading;
        end
        return;
      end
      if (!calibrating && clr) heading = 0;
      avg       = (longint'(rate) + prev_rate) * (ONE / 2);
      prev_rate = rate;
      trim      = floor_div((longint'(adc) - center) * ONE, TRIM_DIV) + offset * ONE;
      incr      = avg + trim;
      if (!calibrating) incr += bias;
      heading = sat_add(heading, incr);
      if (calibrating) begin
        win_count++;
        if (win_count >= CAL_LEN) begin
          q = floor_div(sat_sub(win_start, heading), CAL_LEN);
          if (q > BIAS_HI) q = BIAS_HI;
          if (q < BIAS_LO) q = BIAS_LO;
          bias        = q;
          heading     = 0;
          calibrating = 0;
          win_count   = 0;
        end
        return;
      end
      q = floor_div(heading, OUT_DIV * ONE) + OUT_MID;
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < 0) q = 0;
      want.level = q[DRIVE_W-1:0];
      want.clamp = (heading > longint'(OUT_MAX - OUT_MID) * OUT_DIV * ONE) ||
                   (heading < -longint'(OUT_MID) * OUT_DIV * ONE);
      drive_expected.push_back(want);
    endfunction

    function void check_drive(logic [DRIVE_W-1:0] level, logic clamp_bit);
      drive_t want;
      if (drive_expected.size() == 0) begin
        $error("drive_level: got %0d with no sample pending", level);
        mismatches++;
        return;
      end
      want = drive_expected.pop_front();
      if (level !== want.level) begin
        $error("drive_level: expected %0d, got %0d", want.level, level);
        mismatches++;
      end
      if (clamp_bit !== want.clamp) begin
        $error("clamped: expected %0b, got %0b", want.clamp, clamp_bit);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic                         func;
  logic signed [RATE_W-1:0]     rate_z;
  logic [TRIM_W-1:0]            trim_adc;
  logic                         clear_heading;
  logic                         out_valid;
  logic                         out_ready;
  logic [DRIVE_W-1:0]           drive_level;
  logic                         clamped;

  bit no_idle = 1'b0;
  int samples_sent = 0;
  int idle_cycles = 0;

  heading_scoreboard sb = new();

  always #1 clk = ~clk;

  gyro_heading_integrator #(
    .CAL_SAMPLES(CAL_LEN),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .rate_z       (rate_z),
    .trim_adc     (trim_adc),
    .clear_heading(clear_heading),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_level  (drive_level),
    .clamped      (clamped)
  );

  // beat monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.advance_heading(func, rate_z, trim_adc, clear_heading);
      if (out_valid && out_ready) sb.check_drive(drive_level, clamped);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side: random stall before each beat
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic signed [RATE_W-1:0] rand_rate(int mode);
    logic signed [RATE_W-1:0] r;
    r = RATE_W'($urandom);
    case (mode)
      0: r = r >>> 7;
      1: r = r >>> 2;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(logic fn, logic signed [RATE_W-1:0] rate,
                           logic [TRIM_W-1:0] adc, logic clr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= fn;
    rate_z        <= rate;
    trim_adc      <= adc;
    clear_heading <= clr;
    do @(posedge clk); while (!in_ready);
    if (fn == FUNC_SAMPLE) samples_sent++;
  endtask

  task automatic send_start();
    send_beat(FUNC_CAL_START, RATE_W'($urandom), TRIM_W'($urandom), 1'($urandom));
  endtask

  // hold off input until every drive result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_trim(logic [CFG_DATA_W-1:0] center_word,
                          logic [CFG_DATA_W-1:0] offset_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TRIM_CENTER;
    cfg_wdata <= center_word;
    @(posedge clk);
    sb.write_reg(CFG_TRIM_CENTER, center_word);
    cfg_index <= CFG_TRIM_OFFSET;
    cfg_wdata <= offset_word;
    @(posedge clk);
    sb.write_reg(CFG_TRIM_OFFSET, offset_word);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_sequence();
    int kind;
    int len;
    int mode;
    kind    = $urandom_range(0, 99);
    no_idle = ($urandom_range(0, 3) == 0);
    if (kind < 5) begin
      // full calibration window, mostly quiet rates so the learned bias stays sane
      send_start();
      mode = ($urandom_range(0, 9) == 0) ? 2 : 0;
      for (int i = 0; i < CAL_LEN; i++) begin
        if ($urandom_range(0, 49) == 0) send_start();
        send_beat(FUNC_SAMPLE, rand_rate(mode), TRIM_W'($urandom), 1'($urandom));
      end
    end else if (kind < 8) begin
      send_start();
    end else begin
      len  = $urandom_range(1, 30);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        send_beat(FUNC_SAMPLE, rand_rate(mode), TRIM_W'($urandom),
                  (i == 0) ? 1'($urandom) : 1'($urandom_range(0, 15) == 0));
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    func          <= FUNC_SAMPLE;
    rate_z        <= '0;
    trim_adc      <= '0;
    clear_heading <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_TRIM_CENTER;
    cfg_wdata     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: full-scale rates into both clamps, then a window start
    send_beat(FUNC_SAMPLE, 16'sh0000, 10'd512, 1'b1);
    repeat (9) send_beat(FUNC_SAMPLE, 16'sh7FFF, 10'd1023, 1'b0);
    send_beat(FUNC_SAMPLE, 16'sh8000, 10'd0, 1'b1);
    repeat (9) send_beat(FUNC_SAMPLE, 16'sh8000, 10'd0, 1'b0);
    send_beat(FUNC_CAL_START, 16'sh7FFF, 10'd1023, 1'b1);
    // second start inside the window is dropped
    send_beat(FUNC_CAL_START, 16'sh8000, 10'd0, 1'b0);
    // clear is ignored while calibrating
    send_beat(FUNC_SAMPLE, 16'sd100, 10'd512, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1: set_trim(11'h400, 11'h400);   // center 0 (bit 10 dropped), offset -1024
          2: set_trim(11'd1023, 11'd1023);
          default: set_trim(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        endcase
      end
      while (samples_sent < (ph + 1) * SAMPLES_PER_PHASE) run_sequence();
    end

    drain();
    if (sb.pending() != 0) begin
      $error("drive_level: %0d results never arrived", sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
